// ===== src/cdl_pkg.sv =====
// Shared types and constants for the chaotic dual LFO step block.
// Used by cdl_div, cdl_mul and chaotic_dual_lfo_step; depends on nothing.
package cdl_pkg;

  typedef struct packed {
    logic        [23:0] phase_increment;
    logic signed [15:0] clock_level;
    logic               clock_present;
    logic signed [15:0] character_cv;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_a;
    logic signed [15:0] out_b;
    logic               step_trigger;
  } res_t;

  typedef enum logic [2:0] {
    REG_CHARACTER = 3'd0,
    REG_GLIDE     = 3'd1,
    REG_SPREAD    = 3'd2,
    REG_DEPTH     = 3'd3,
    REG_CLK_LOW   = 3'd4,
    REG_CLK_HIGH  = 3'd5,
    REG_MIN_INC   = 3'd6,
    REG_MAX_INC   = 3'd7
  } cfg_reg_t;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [7:0]  PULSE_SAMPLES = 8'd48;
  localparam logic [31:0] R_BASE   = 32'd3865470566;
  localparam logic [28:0] R_SPAN   = 29'd418759311;
  localparam logic [31:0] R_RESET  = 32'd4080218931;
  localparam logic [31:0] SEED_A   = 32'd1331439862;
  localparam logic [31:0] SEED_B   = 32'd2877628088;
  localparam logic [31:0] MAP_LO   = 32'd4295;
  localparam logic [31:0] MAP_HI   = 32'd4294962001;
  localparam logic [24:0] ONE_Q24  = 25'h1000000;
  localparam logic [15:0] SHAPE_MIN = 16'd6;
  // ceil(2^23 / 10): exact quotient by ten for values below 2^22
  localparam logic [19:0] RECIP10  = 20'd838861;
  localparam logic [16:0] T_ONE    = 17'd65536;
  localparam logic [17:0] SMOOTH_K = 18'd196608;
  localparam logic [4:0]  DIV_STEPS = 5'd16;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== src/cdl_div.sv =====
// Restoring divider, one quotient bit per cycle, for the glide ramp.
// Depends on cdl_pkg; caller guarantees the quotient fits 16 bits.
module cdl_div (
  input  logic               clk,
  input  logic               rst,
  input  cdl_pkg::div_ctl_t  ctl,
  input  logic [31:0]        num,
  input  logic [15:0]        den,
  output cdl_pkg::div_sts_t  sts,
  output logic [15:0]        quot
);

  logic [15:0] rem;
  logic [15:0] low;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, low[15]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem  <= num[31:16];
        low  <= num[15:0];
        quot <= '0;
        cnt  <= cdl_pkg::DIV_STEPS;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
        low  <= {low[14:0], 1'b0};
        quot <= {quot[14:0], fits};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== src/cdl_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on cdl_pkg for the operand width.
module cdl_mul (
  input  logic                               clk,
  input  logic signed [cdl_pkg::MUL_W-1:0]   op_a,
  input  logic signed [cdl_pkg::MUL_W-1:0]   op_b,
  output logic signed [cdl_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ===== src/chaotic_dual_lfo_step.sv =====
// Chaotic dual LFO step: sequencer around one shared multiplier and a divider.
// Depends on cdl_pkg, cdl_mul and cdl_div.
//
//  channel | signals                         | payload
//  item    | item_valid, item_ready          | item (cdl_pkg::item_t)
//  res     | res_valid, res_ready            | res  (cdl_pkg::res_t)
//  cfg     | cfg_valid, cfg_ready            | cfg_index, cfg_data
//
// An item passes S_CV, S_CH and S_R; with a step it then iterates both maps (S_SQ, S_P,
// S_RP, S_WB for each) before S_GL, without one it goes straight to S_GL. When the glide
// needs the divider S_DIV follows; then S_TT through S_BD, and S_OUT offers the result.
// After reset the maps are iterated twice before the first transfer.
// One item is in work at a time; a held result stalls only the final state, S_OUT.
// Config writes are always taken.
module chaotic_dual_lfo_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  cdl_pkg::item_t      item,
  output logic                res_valid,
  input  logic                res_ready,
  output cdl_pkg::res_t       res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CV, S_CH, S_R, S_SQ, S_P, S_RP, S_WB, S_GL, S_DIV,
    S_TT, S_T2, S_S, S_MA, S_MB, S_MS, S_SP, S_BN, S_BD, S_OUT
  } state_t;

  state_t state;

  logic        [15:0] character_knob, glide_shape, spread_amount, depth_amount;
  logic signed [15:0] clock_low_threshold, clock_high_threshold;
  logic        [23:0] min_increment, max_increment;

  logic [24:0]        phase_acc;
  logic [31:0]        map_a, map_b;
  logic signed [15:0] prev_val_a, next_val_a, prev_val_b, next_val_b;
  logic               schmitt_high;
  logic [7:0]         pulse_left;

  cdl_pkg::item_t     cur;
  logic               step_r, trig, sel, booting, init_pass;
  logic [31:0]        r, p;
  logic [16:0]        t, s;
  logic signed [15:0] a_norm, b_free, b_norm, oa;

  logic signed [cdl_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cdl_pkg::PROD_W-1:0] prod;

  cdl_pkg::div_ctl_t div_ctl;
  cdl_pkg::div_sts_t div_sts;
  logic [15:0]       div_q;

  // Phase, clock and pulse update
  logic [23:0] inc_lo, inc_c;
  logic [24:0] sum, phase_next;
  logic        step_next, sh_next;
  logic [7:0]  pulse_set, pulse_next;
  logic [15:0] cv_abs;
  logic [19:0] cv_mag;

  always_comb begin
    inc_lo     = (cur.phase_increment < min_increment) ? min_increment : cur.phase_increment;
    inc_c      = (inc_lo > max_increment) ? max_increment : inc_lo;
    sum        = phase_acc + {1'b0, inc_c};
    phase_next = sum;
    step_next  = 1'b0;
    sh_next    = schmitt_high;
    if (cur.clock_present) begin
      if (schmitt_high) begin
        if (cur.clock_level <= clock_low_threshold) sh_next = 1'b0;
      end else if (cur.clock_level >= clock_high_threshold) begin
        sh_next    = 1'b1;
        step_next  = 1'b1;
        phase_next = '0;
      end
      if (phase_next > cdl_pkg::ONE_Q24) phase_next = cdl_pkg::ONE_Q24;
    end else if (sum >= cdl_pkg::ONE_Q24) begin
      phase_next = sum - cdl_pkg::ONE_Q24;
      step_next  = 1'b1;
    end
    pulse_set  = step_next ? cdl_pkg::PULSE_SAMPLES : pulse_left;
    pulse_next = (pulse_set != 8'd0) ? pulse_set - 8'd1 : 8'd0;
    cv_abs     = cur.character_cv[15] ? 16'(-cur.character_cv) : cur.character_cv;
    cv_mag     = {cv_abs, 4'b0};
  end

  // Character, clamped to [0, 1.0]
  logic [15:0]        cv_q;
  logic signed [17:0] ch_raw;
  logic [16:0]        ch;

  always_comb begin
    cv_q   = prod[38:23];
    ch_raw = cur.character_cv[15] ? $signed({2'b0, character_knob}) - $signed({2'b0, cv_q})
                                  : $signed({2'b0, character_knob}) + $signed({2'b0, cv_q});
    if (ch_raw < 0)                 ch = '0;
    else if (ch_raw > 18'sd65536)   ch = cdl_pkg::T_ONE;
    else                            ch = ch_raw[16:0];
  end

  logic [31:0] x_cur, x_new, p_new;
  logic signed [15:0] bip;
  logic [24:0] frac;
  logic signed [16:0] d_a, d_b, d_ab;

  always_comb begin
    x_cur = sel ? map_b : map_a;
    p_new = x_cur - 32'((prod[63:0] + 64'hFFFF_FFFF) >> 32);
    x_new = prod[61:30];
    bip   = $signed({~x_new[31], x_new[30:16]});
    frac  = (phase_acc > cdl_pkg::ONE_Q24) ? cdl_pkg::ONE_Q24 : phase_acc;
    d_a   = 17'(next_val_a) - 17'(prev_val_a);
    d_b   = 17'(next_val_b) - 17'(prev_val_b);
    d_ab  = 17'(b_free) - 17'(a_norm);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CV: begin
        mul_a = $signed({13'b0, cv_mag});
        mul_b = $signed({13'b0, cdl_pkg::RECIP10});
      end
      S_CH: begin
        mul_a = $signed({16'b0, ch});
        mul_b = $signed({4'b0, cdl_pkg::R_SPAN});
      end
      S_SQ: begin
        mul_a = $signed({1'b0, x_cur});
        mul_b = $signed({1'b0, x_cur});
      end
      S_RP: begin
        mul_a = $signed({1'b0, r});
        mul_b = $signed({1'b0, p});
      end
      S_TT: begin
        mul_a = $signed({16'b0, t});
        mul_b = $signed({16'b0, t});
      end
      S_T2: begin
        mul_a = $signed({16'b0, prod[32:16]});
        mul_b = $signed({15'b0, 18'(cdl_pkg::SMOOTH_K - {t, 1'b0})});
      end
      S_MA: begin
        mul_a = 33'(d_a);
        mul_b = $signed({16'b0, s});
      end
      S_MB: begin
        mul_a = 33'(d_b);
        mul_b = $signed({16'b0, s});
      end
      S_MS: begin
        mul_a = 33'(a_norm);
        mul_b = $signed({17'b0, depth_amount});
      end
      S_SP: begin
        mul_a = 33'(d_ab);
        mul_b = $signed({17'b0, spread_amount});
      end
      S_BD, S_OUT: begin
        mul_a = 33'(b_norm);
        mul_b = $signed({17'b0, depth_amount});
      end
      default: ;
    endcase
  end

  logic glide_full;
  assign glide_full = (glide_shape <= cdl_pkg::SHAPE_MIN) || (frac >= {1'b0, glide_shape, 8'h0});
  assign div_ctl.start = (state == S_GL) && !glide_full;

  cdl_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  cdl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  ({frac[23:0], 8'h0}),
    .den  (glide_shape),
    .sts  (div_sts),
    .quot (div_q)
  );

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_INIT;
      character_knob       <= '0;
      glide_shape          <= '0;
      spread_amount        <= '0;
      depth_amount         <= 16'hFFFF;
      clock_low_threshold  <= 16'sd410;
      clock_high_threshold <= 16'sd4096;
      min_increment        <= 24'd7;
      max_increment        <= 24'd139810;
      phase_acc            <= '0;
      schmitt_high         <= 1'b0;
      pulse_left           <= '0;
      map_a                <= cdl_pkg::SEED_A;
      map_b                <= cdl_pkg::SEED_B;
      r                    <= cdl_pkg::R_RESET;
      sel                  <= 1'b0;
      booting              <= 1'b1;
      init_pass            <= 1'b0;
      res_valid            <= 1'b0;
      step_r               <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cdl_pkg::cfg_reg_t'(cfg_index))
          cdl_pkg::REG_CHARACTER: character_knob       <= cfg_data[15:0];
          cdl_pkg::REG_GLIDE:     glide_shape          <= cfg_data[15:0];
          cdl_pkg::REG_SPREAD:    spread_amount        <= cfg_data[15:0];
          cdl_pkg::REG_DEPTH:     depth_amount         <= cfg_data[15:0];
          cdl_pkg::REG_CLK_LOW:   clock_low_threshold  <= $signed(cfg_data[15:0]);
          cdl_pkg::REG_CLK_HIGH:  clock_high_threshold <= $signed(cfg_data[15:0]);
          cdl_pkg::REG_MIN_INC:   min_increment        <= cfg_data;
          cdl_pkg::REG_MAX_INC:   max_increment        <= cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;

      case (state)
        S_INIT: state <= S_SQ;
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_CV;
          end
        end
        S_CV: begin
          phase_acc    <= phase_next;
          schmitt_high <= sh_next;
          step_r       <= step_next;
          trig         <= (pulse_set != 8'd0);
          pulse_left   <= pulse_next;
          state        <= S_CH;
        end
        S_CH: state <= S_R;
        S_R: begin
          r <= cdl_pkg::R_BASE + prod[47:16];
          if (step_r) begin
            // reseed a map that has fallen out of the valid range
            if (map_a < cdl_pkg::MAP_LO || map_a > cdl_pkg::MAP_HI) map_a <= cdl_pkg::SEED_A;
            if (map_b < cdl_pkg::MAP_LO || map_b > cdl_pkg::MAP_HI) map_b <= cdl_pkg::SEED_B;
            sel   <= 1'b0;
            state <= S_SQ;
          end else begin
            state <= S_GL;
          end
        end
        S_SQ: state <= S_P;
        S_P: begin
          p     <= p_new;
          state <= S_RP;
        end
        S_RP: state <= S_WB;
        S_WB: begin
          if (sel) map_b <= x_new;
          else     map_a <= x_new;
          if (booting && !init_pass) begin
            if (sel) prev_val_b <= bip;
            else     prev_val_a <= bip;
          end else if (booting) begin
            if (sel) next_val_b <= bip;
            else     next_val_a <= bip;
          end else if (sel) begin
            prev_val_b <= next_val_b;
            next_val_b <= bip;
          end else begin
            prev_val_a <= next_val_a;
            next_val_a <= bip;
          end
          sel <= ~sel;
          if (!sel) begin
            state <= S_SQ;
          end else if (booting && !init_pass) begin
            init_pass <= 1'b1;
            state     <= S_SQ;
          end else if (booting) begin
            booting <= 1'b0;
            state   <= S_IDLE;
          end else begin
            state <= S_GL;
          end
        end
        S_GL: begin
          if (glide_full) begin
            t     <= cdl_pkg::T_ONE;
            state <= S_TT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            t     <= {1'b0, div_q};
            state <= S_TT;
          end
        end
        S_TT: state <= S_T2;
        S_T2: state <= S_S;
        S_S: begin
          s     <= prod[32:16];
          state <= S_MA;
        end
        S_MA: state <= S_MB;
        S_MB: begin
          a_norm <= 16'(17'(prev_val_a) + prod[32:16]);
          state  <= S_MS;
        end
        S_MS: begin
          b_free <= 16'(17'(prev_val_b) + prod[32:16]);
          state  <= S_SP;
        end
        S_SP: begin
          oa    <= prod[31:16];
          state <= S_BN;
        end
        S_BN: begin
          b_norm <= 16'(17'(a_norm) + prod[32:16]);
          state  <= S_BD;
        end
        S_BD: state <= S_OUT;
        S_OUT: begin
          // hold until the previous result has been transferred
          if (!res_valid || res_ready) begin
            res.out_a        <= oa;
            res.out_b        <= prod[31:16];
            res.step_trigger <= trig;
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item in work");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase_acc <= cdl_pkg::ONE_Q24)
    else $error("phase accumulator above one cycle");

  a_pulse_bound: assert property (@(posedge clk) disable iff (rst)
    pulse_left < cdl_pkg::PULSE_SAMPLES)
    else $error("pulse counter out of range");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == S_DIV)
    else $error("divider finished outside glide division");

  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_sts.busy |-> state == S_DIV)
    else $error("divider running outside glide division");

endmodule
